[rtl/pbp_pkg.sv]
// Shared types and constants of the page buffer pool slot manager.
// Used by the memory, the sequencer, the top level and the port checker.
// No dependencies.
package pbp_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PAGE_W   = 24;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PIN_W    = 16;
  localparam int unsigned CFG_W    = 7;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [PIN_W-1:0] PIN_MAX    = '1;
  localparam logic [CFG_W-1:0] CFG_RESET  = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_FETCH   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_FLUSH   = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT         = 3'd0,
    ST_FILLED      = 3'd1,
    ST_REPLACED    = 3'd2,
    ST_NO_VICTIM   = 3'd3,
    ST_RELEASED    = 3'd4,
    ST_UNPINNED    = 3'd5,
    ST_FLUSH_ENTRY = 3'd6,
    ST_FLUSH_EMPTY = 3'd7
  } status_e;

  // Control strobes from the sequencer to the slot memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // One result beat as held in the output register.
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] read_page;
    logic [PAGE_W-1:0] write_page;
    logic [PIN_W-1:0]  pin_count;
    logic              last;
  } out_beat_t;

  function automatic out_beat_t mk_beat(status_e st, logic [SLOT_W-1:0] slot,
                                        logic [PAGE_W-1:0] rd, logic [PAGE_W-1:0] wr,
                                        logic [PIN_W-1:0] pin, logic last);
    out_beat_t b;
    b.status     = st;
    b.slot       = slot;
    b.read_page  = rd;
    b.write_page = wr;
    b.pin_count  = pin;
    b.last       = last;
    return b;
  endfunction

endpackage

[rtl/pbp_mem.sv]
// Slot memory: one entry per slot holding dirty mark, pin count and page.
// One write port and one read port with registered read data.
// Depends on pbp_pkg for the control strobe struct.
module pbp_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned WIDTH = 41
) (
  input  logic                 clk_i,
  input  pbp_pkg::mem_ctl_t    ctl_i,
  input  logic [AW-1:0]        raddr_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  output logic [WIDTH-1:0]     rdata_o
);
  import pbp_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/pbp_ctrl.sv]
// Sequencer of the slot manager: takes one request, scans the slot memory,
// updates the touched entry in place and produces the result beats.
// Depends on pbp_pkg; drives the ports of pbp_mem.
module pbp_ctrl #(
  parameter int unsigned SW    = 6,
  parameter int unsigned CW    = 7,
  parameter int unsigned PW    = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pbp_pkg::MODE_W-1:0]   mode_i,
  input  logic [pbp_pkg::PAGE_W-1:0]   page_i,
  input  logic [pbp_pkg::SLOT_W-1:0]   idx_i,
  input  logic                         mod_i,
  input  logic [CW-1:0]                lim_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pbp_pkg::out_beat_t           out_o,
  output pbp_pkg::mem_ctl_t            mem_ctl_o,
  output logic [SW-1:0]                mem_raddr_o,
  output logic [SW-1:0]                mem_waddr_o,
  output logic [PW+pbp_pkg::PIN_W:0]   mem_wdata_o,
  input  logic [PW+pbp_pkg::PIN_W:0]   mem_rdata_i
);
  import pbp_pkg::*;

  localparam int unsigned EW = PW + PIN_W + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_REL   = 6'b000100,
    S_FLRD  = 6'b001000,
    S_FLCHK = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     filled_q, filled_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic              chk_v_q, chk_v_d;
  logic [SW-1:0]     chk_idx_q, chk_idx_d;
  logic              vic_v_q, vic_v_d;
  logic [SW-1:0]     vic_idx_q, vic_idx_d;
  logic [PW-1:0]     vic_page_q, vic_page_d;
  logic              vic_dirty_q, vic_dirty_d;
  logic [PW-1:0]     page_q, page_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              mod_q, mod_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  // Fields of the entry that the memory returned.
  logic [PW-1:0]     rd_page;
  logic [PIN_W-1:0]  rd_pin;
  logic              rd_dirty;
  logic              hit;
  logic [PIN_W-1:0]  pin_inc;
  logic [CW-1:0]     ptr_inc;

  assign rd_page  = mem_rdata_i[PW-1:0];
  assign rd_pin   = mem_rdata_i[PW +: PIN_W];
  assign rd_dirty = mem_rdata_i[EW-1];
  assign hit      = chk_v_q && (rd_page == page_q);
  assign pin_inc  = (rd_pin == PIN_MAX) ? rd_pin : rd_pin + PIN_W'(1);
  assign ptr_inc  = ptr_q + CW'(1);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Request decode, scan sequencing and read-modify-write of one entry.
  always_comb begin
    state_d     = state_q;
    filled_d    = filled_q;
    ptr_d       = ptr_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    vic_v_d     = vic_v_q;
    vic_idx_d   = vic_idx_q;
    vic_page_d  = vic_page_q;
    vic_dirty_d = vic_dirty_q;
    page_d      = page_q;
    idx_d       = idx_q;
    mod_d       = mod_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_ctl_o   = '0;
    mem_raddr_o = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          page_d = page_i[PW-1:0];
          idx_d  = idx_i;
          mod_d  = mod_i;
          unique case (mode_e'(mode_i))
            MODE_FETCH: begin
              if (page_i[PW-1:0] == '0) begin
                out_d       = mk_beat(ST_NO_VICTIM, '0, '0, '0, '0, 1'b1);
                out_valid_d = 1'b1;
                state_d     = S_OUT;
              end else begin
                ptr_d   = '0;
                chk_v_d = 1'b0;
                vic_v_d = 1'b0;
                state_d = S_SCAN;
              end
            end
            MODE_RELEASE: begin
              if ({1'b0, idx_i} >= (SLOT_W + 1)'(filled_q)) begin
                out_d       = mk_beat(ST_UNPINNED, idx_i, '0, '0, '0, 1'b1);
                out_valid_d = 1'b1;
                state_d     = S_OUT;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = idx_i[SW-1:0];
                state_d         = S_REL;
              end
            end
            MODE_FLUSH: begin
              if (filled_q == '0) begin
                out_d       = mk_beat(ST_FLUSH_EMPTY, '0, '0, '0, '0, 1'b1);
                out_valid_d = 1'b1;
                state_d     = S_OUT;
              end else begin
                ptr_d   = '0;
                state_d = S_FLRD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // One read issued per cycle; the entry read last cycle is compared now.
      // The first unpinned slot below the limit is kept as the victim.
      S_SCAN: begin
        if (chk_v_q && !vic_v_q && (rd_pin == '0) && (CW'(chk_idx_q) < lim_i)) begin
          vic_v_d     = 1'b1;
          vic_idx_d   = chk_idx_q;
          vic_page_d  = rd_page;
          vic_dirty_d = rd_dirty;
        end
        if (hit) begin
          mem_ctl_o.wr_en = 1'b1;
          mem_waddr_o     = chk_idx_q;
          mem_wdata_o     = {rd_dirty, pin_inc, rd_page};
          out_d           = mk_beat(ST_HIT, SLOT_W'(chk_idx_q), '0, '0, pin_inc, 1'b1);
          out_valid_d     = 1'b1;
          chk_v_d         = 1'b0;
          state_d         = S_OUT;
        end else if (ptr_q < filled_q) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = ptr_q[SW-1:0];
          chk_v_d         = 1'b1;
          chk_idx_d       = ptr_q[SW-1:0];
          ptr_d           = ptr_inc;
        end else if (chk_v_q) begin
          chk_v_d = 1'b0;
        end else begin
          // Miss: fill the next empty slot below the limit, else replace the victim, else report no victim.
          out_valid_d = 1'b1;
          state_d     = S_OUT;
          if (filled_q < lim_i) begin
            mem_ctl_o.wr_en = 1'b1;
            mem_waddr_o     = filled_q[SW-1:0];
            mem_wdata_o     = {1'b0, PIN_W'(1), page_q};
            filled_d        = filled_q + CW'(1);
            out_d = mk_beat(ST_FILLED, SLOT_W'(filled_q), PAGE_W'(page_q), '0,
                            PIN_W'(1), 1'b1);
          end else if (vic_v_q) begin
            mem_ctl_o.wr_en = 1'b1;
            mem_waddr_o     = vic_idx_q;
            mem_wdata_o     = {1'b0, PIN_W'(1), page_q};
            out_d = mk_beat(ST_REPLACED, SLOT_W'(vic_idx_q), PAGE_W'(page_q),
                            vic_dirty_q ? PAGE_W'(vic_page_q) : '0, PIN_W'(1), 1'b1);
          end else begin
            out_d = mk_beat(ST_NO_VICTIM, '0, '0, '0, '0, 1'b1);
          end
        end
      end

      // Release: entry data is ready, write it back updated.
      S_REL: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = idx_q[SW-1:0];
        out_valid_d     = 1'b1;
        state_d         = S_OUT;
        if (rd_pin == '0) begin
          mem_wdata_o = {rd_dirty | mod_q, rd_pin, rd_page};
          out_d       = mk_beat(ST_UNPINNED, idx_q, '0, '0, '0, 1'b1);
        end else begin
          mem_wdata_o = {rd_dirty | mod_q, rd_pin - PIN_W'(1), rd_page};
          out_d       = mk_beat(ST_RELEASED, idx_q, '0, '0, rd_pin - PIN_W'(1), 1'b1);
        end
      end

      S_FLRD: begin
        mem_ctl_o.rd_en = 1'b1;
        mem_raddr_o     = ptr_q[SW-1:0];
        state_d         = S_FLCHK;
      end

      // Flush: list the entry and clear its dirty mark.
      S_FLCHK: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = ptr_q[SW-1:0];
        mem_wdata_o     = {1'b0, rd_pin, rd_page};
        out_d = mk_beat(ST_FLUSH_ENTRY, SLOT_W'(ptr_q[SW-1:0]), '0, PAGE_W'(rd_page),
                        rd_pin, ptr_inc == filled_q);
        out_valid_d = 1'b1;
        ptr_d       = ptr_inc;
        state_d     = S_OUT;
      end

      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = out_q.last ? S_IDLE : S_FLRD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filled_q    <= '0;
      ptr_q       <= '0;
      chk_v_q     <= 1'b0;
      vic_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      ptr_q       <= ptr_d;
      chk_v_q     <= chk_v_d;
      vic_v_q     <= vic_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    vic_idx_q   <= vic_idx_d;
    vic_page_q  <= vic_page_d;
    vic_dirty_q <= vic_dirty_d;
    page_q      <= page_d;
    idx_q       <= idx_d;
    mod_q       <= mod_d;
    out_q       <= out_d;
  end

endmodule

[rtl/pinned_page_buffer_pool_core.sv]
// Page buffer pool slot manager. Fetch: the tag and victim scan reads one slot per cycle,
// then the result beat is registered. Release: the entry is read, then written back.
// Flush: each filled slot is read, then written back as its beat is listed; output stalls hold the flush.
// One request is processed at a time; the next is taken after the last beat leaves.
// Reset (rst_ni low, asynchronous) empties the pool and sets the slot limit to 64;
// the slot memory is not cleared, the fill count keeps unwritten slots from being read.
module pinned_page_buffer_pool_core #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned PAGE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: slot limit.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbp_pkg::CFG_W-1:0]           cfg_data_i,
  // Requests.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // page_number[23:0], slot_index[29:24], modified[30], zero pad[31]
  input  logic [pbp_pkg::IN_TDATA_W-1:0]      s_tdata,
  // mode[1:0]
  input  logic [pbp_pkg::MODE_W-1:0]          s_tuser,
  // Results.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // slot[5:0], read_page[29:6], write_page[53:30], pin_count[69:54], zero pad[71:70]
  output logic [pbp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // status[2:0]
  output logic [pbp_pkg::STATUS_W-1:0]        m_tuser,
  output logic                                m_tlast
);
  import pbp_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int unsigned EW = PW + PIN_W + 1;

  logic [CFG_W-1:0] cfg_q;
  logic [CW-1:0]    lim;
  mem_ctl_t         mem_ctl;
  logic [SW-1:0]    mem_raddr;
  logic [SW-1:0]    mem_waddr;
  logic [EW-1:0]    mem_wdata;
  logic [EW-1:0]    mem_rdata;
  out_beat_t        beat;

  // Slot limit register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Effective limit: zero acts as one, values above the slot count clamp.
  always_comb begin
    priority if (cfg_q == '0) begin
      lim = CW'(1);
    end else if (cfg_q > CFG_W'(SLOTS)) begin
      lim = CW'(SLOTS);
    end else begin
      lim = cfg_q[CW-1:0];
    end
  end

  pbp_ctrl #(
    .SW    (SW),
    .CW    (CW),
    .PW    (PW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .mode_i      (s_tuser),
    .page_i      (s_tdata[PAGE_W-1:0]),
    .idx_i       (s_tdata[PAGE_W +: SLOT_W]),
    .mod_i       (s_tdata[PAGE_W + SLOT_W]),
    .lim_i       (lim),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_o       (beat),
    .mem_ctl_o   (mem_ctl),
    .mem_raddr_o (mem_raddr),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  pbp_mem #(
    .DEPTH (SLOTS),
    .AW    (SW),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .raddr_i (mem_raddr),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Result beat packing.
  assign m_tdata = {2'b00, beat.pin_count, beat.write_page, beat.read_page, beat.slot};
  assign m_tuser = beat.status;
  assign m_tlast = beat.last;

endmodule

[rtl/pbp_checker.sv]
// Port-level checks of the page buffer pool slot manager.
// Depends on pbp_pkg; bound to pinned_page_buffer_pool_core below.
module pbp_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [pbp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic [pbp_pkg::STATUS_W-1:0]        m_tuser,
  input  logic                                m_tlast
);
  import pbp_pkg::*;

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // No request is taken while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready && m_tvalid))
    else $error("request ready while a result is pending");

  // Only flush listings span several beats.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser != ST_FLUSH_ENTRY) |-> m_tlast)
    else $error("single result without last");

  // A refused fetch carries no slot, pages or pins.
  a_no_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == ST_NO_VICTIM) |-> (m_tdata == '0))
    else $error("no-victim result with nonzero payload");

  // A fresh fill is pinned once and needs no write-back.
  a_fill_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == ST_FILLED) |-> (m_tdata[69:54] == 16'd1)
      && (m_tdata[53:30] == '0))
    else $error("filled slot with wrong pin count or write-back");

endmodule

bind pinned_page_buffer_pool_core pbp_checker u_pbp_checker (.*);
